/* sv/eau_pkg.sv */
package eau_pkg;

	localparam int unsigned WordW  = 16;
	localparam int unsigned PairW  = 2 * WordW;
	localparam int unsigned CountW = 6;

	// word offsets on the bus
	localparam logic [2:0] OFS_DIV   = 3'd0;
	localparam logic [2:0] OFS_AC    = 3'd1;
	localparam logic [2:0] OFS_MQ    = 3'd2;
	localparam logic [2:0] OFS_MUL   = 3'd3;
	localparam logic [2:0] OFS_SHL   = 3'd6;
	localparam logic [2:0] OFS_SHR   = 3'd7;

	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	localparam logic [WordW-1:0] WORD_ONES = 16'hffff;
	localparam logic [PairW-1:0] PAIR_MIN  = 32'h8000_0000;

	typedef enum logic [2:0] {
		OP_LOAD_AC,
		OP_LOAD_MQ,
		OP_MUL,
		OP_DIV,
		OP_SHIFT
	} eau_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DIV_FIX,
		ST_SHL,
		ST_SHR
	} eau_state_t;

	typedef struct packed {
		logic             start;
		eau_op_t          op;
		logic [WordW-1:0] data;
	} eau_cmd_t;

endpackage

/* sv/eau_engine.sv */
module eau_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  eau_pkg::eau_cmd_t             cmd,
	output logic [eau_pkg::WordW-1:0]     ac,
	output logic [eau_pkg::WordW-1:0]     mq,
	output logic                          busy
);

	eau_pkg::eau_state_t state_q, state_d;

	logic [eau_pkg::WordW-1:0]  ac_q, mq_q;
	logic [eau_pkg::PairW-1:0]  pair_q;
	logic [eau_pkg::WordW:0]    rem_q;
	logic [eau_pkg::WordW:0]    opnd_q;
	logic [eau_pkg::CountW-1:0] cnt_q;
	logic                       num_neg_q, den_neg_q;

	logic                       last_step;
	logic [eau_pkg::WordW:0]    mul_addend, mul_sum;
	logic [eau_pkg::WordW+2:0]  div_trial;
	logic                       div_ge;
	logic [eau_pkg::PairW-1:0]  cur_pair, pair_neg;
	logic                       div_zero;
	logic [eau_pkg::WordW:0]    den_mag;
	logic [eau_pkg::CountW-1:0] shift_amt;
	logic                       shift_right;

	assign ac   = ac_q;
	assign mq   = mq_q;
	assign busy = (state_q != eau_pkg::ST_IDLE);

	assign last_step = (cnt_q == eau_pkg::CountW'(1));
	assign cur_pair  = {ac_q, mq_q};
	assign pair_neg  = eau_pkg::PairW'(0) - cur_pair;

	// multiply: add the multiplicand per multiplier bit, subtract it for the sign bit
	assign mul_addend = last_step ? (17'd0 - opnd_q) : opnd_q;
	assign mul_sum    = rem_q + (pair_q[0] ? mul_addend : 17'd0);

	// restoring divide: one quotient bit per step
	assign div_trial = {1'b0, rem_q, pair_q[eau_pkg::PairW-1]} - {2'b00, opnd_q};
	assign div_ge    = !div_trial[eau_pkg::WordW+2];

	assign div_zero = (cmd.data == '0) ||
		((cur_pair == eau_pkg::PAIR_MIN) && (cmd.data == eau_pkg::WORD_ONES));
	assign den_mag  = cmd.data[eau_pkg::WordW-1] ?
		(17'h10000 - {1'b0, cmd.data}) : {1'b0, cmd.data};

	// counts 32..63 become a right shift by 64 minus the count
	assign shift_right = cmd.data[eau_pkg::CountW-1];
	assign shift_amt   = shift_right ?
		eau_pkg::CountW'(7'd64 - {1'b0, cmd.data[eau_pkg::CountW-1:0]}) :
		cmd.data[eau_pkg::CountW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eau_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			eau_pkg::ST_IDLE: begin
				if (cmd.start) begin
					case (cmd.op)
						eau_pkg::OP_MUL: state_d = eau_pkg::ST_MUL;
						eau_pkg::OP_DIV: begin
							if (!div_zero) state_d = eau_pkg::ST_DIV;
						end
						eau_pkg::OP_SHIFT: begin
							if (shift_amt != '0) begin
								state_d = shift_right ? eau_pkg::ST_SHR : eau_pkg::ST_SHL;
							end
						end
						default: state_d = eau_pkg::ST_IDLE;
					endcase
				end
			end
			eau_pkg::ST_MUL: begin
				if (last_step) state_d = eau_pkg::ST_IDLE;
			end
			eau_pkg::ST_DIV: begin
				if (last_step) state_d = eau_pkg::ST_DIV_FIX;
			end
			eau_pkg::ST_DIV_FIX: state_d = eau_pkg::ST_IDLE;
			eau_pkg::ST_SHL, eau_pkg::ST_SHR: begin
				if (last_step) state_d = eau_pkg::ST_IDLE;
			end
			default: state_d = eau_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac_q  <= '0;
			mq_q  <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				eau_pkg::ST_IDLE: begin
					if (cmd.start) begin
						case (cmd.op)
							eau_pkg::OP_LOAD_AC: ac_q <= cmd.data;
							eau_pkg::OP_LOAD_MQ: begin
								mq_q <= cmd.data;
								ac_q <= {eau_pkg::WordW{cmd.data[eau_pkg::WordW-1]}};
							end
							eau_pkg::OP_MUL: begin
								cnt_q <= eau_pkg::CountW'(eau_pkg::WordW);
							end
							eau_pkg::OP_DIV: begin
								if (div_zero) begin
									ac_q <= '0;
									mq_q <= '0;
								end
								cnt_q <= eau_pkg::CountW'(eau_pkg::PairW);
							end
							eau_pkg::OP_SHIFT: cnt_q <= shift_amt;
							default: cnt_q <= cnt_q;
						endcase
					end
				end
				eau_pkg::ST_MUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (last_step) begin
						ac_q <= mul_sum[eau_pkg::WordW:1];
						mq_q <= {mul_sum[0], pair_q[eau_pkg::WordW-1:1]};
					end
				end
				eau_pkg::ST_DIV: cnt_q <= cnt_q - 1'b1;
				eau_pkg::ST_DIV_FIX: begin
					mq_q <= (num_neg_q ^ den_neg_q) ?
						(16'd0 - pair_q[eau_pkg::WordW-1:0]) : pair_q[eau_pkg::WordW-1:0];
					ac_q <= num_neg_q ?
						(16'd0 - rem_q[eau_pkg::WordW-1:0]) : rem_q[eau_pkg::WordW-1:0];
				end
				eau_pkg::ST_SHL: begin
					cnt_q <= cnt_q - 1'b1;
					if (last_step) begin
						{ac_q, mq_q} <= {pair_q[eau_pkg::PairW-2:0], 1'b0};
					end
				end
				eau_pkg::ST_SHR: begin
					cnt_q <= cnt_q - 1'b1;
					if (last_step) begin
						{ac_q, mq_q} <= {pair_q[eau_pkg::PairW-1], pair_q[eau_pkg::PairW-1:1]};
					end
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// working registers of the serial datapath
	always_ff @(posedge clk) begin
		case (state_q)
			eau_pkg::ST_IDLE: begin
				rem_q <= '0;
				if (cmd.op == eau_pkg::OP_MUL) begin
					opnd_q <= {mq_q[eau_pkg::WordW-1], mq_q};
					pair_q <= {{eau_pkg::WordW{1'b0}}, cmd.data};
				end else if (cmd.op == eau_pkg::OP_DIV) begin
					num_neg_q <= ac_q[eau_pkg::WordW-1];
					den_neg_q <= cmd.data[eau_pkg::WordW-1];
					opnd_q    <= den_mag;
					pair_q    <= ac_q[eau_pkg::WordW-1] ? pair_neg : cur_pair;
				end else begin
					pair_q <= cur_pair;
				end
			end
			eau_pkg::ST_MUL: begin
				rem_q  <= {mul_sum[eau_pkg::WordW], mul_sum[eau_pkg::WordW:1]};
				pair_q <= {pair_q[eau_pkg::PairW-1:eau_pkg::WordW],
					mul_sum[0], pair_q[eau_pkg::WordW-1:1]};
			end
			eau_pkg::ST_DIV: begin
				rem_q  <= div_ge ? div_trial[eau_pkg::WordW:0] :
					{rem_q[eau_pkg::WordW-1:0], pair_q[eau_pkg::PairW-1]};
				pair_q <= {pair_q[eau_pkg::PairW-2:0], div_ge};
			end
			eau_pkg::ST_SHL: pair_q <= {pair_q[eau_pkg::PairW-2:0], 1'b0};
			eau_pkg::ST_SHR: pair_q <= {pair_q[eau_pkg::PairW-1], pair_q[eau_pkg::PairW-1:1]};
			default: pair_q <= pair_q;
		endcase
	end

endmodule

/* sv/extended_arithmetic_unit.sv */
// Bus-mapped 16-bit arithmetic element with an AC:MQ register pair. Each request is one
// read or write access; every request returns exactly one response word (AC or MQ for
// reads at offsets 1 and 2, zero otherwise). Reads, loads and unmapped writes do not start
// the engine. The arithmetic runs on a one-bit-per-cycle shift/add datapath: a multiply runs
// 16 add-shift steps, a divide 32 restoring steps plus a sign fix (no steps for a zero
// divisor or the overflow case), and a shift by count n moves AC:MQ one bit per step, left
// for n below 32 and right by 64-n otherwise (a zero count does not start the engine).
// The next request is taken once the engine is idle and the response register is empty
// or hands its word over in the same cycle; a response that waits holds off the input.
module extended_arithmetic_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // write_data
	input  logic [3:0]  s_tuser,   // action, reg_offset[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // read_data
);

	eau_pkg::eau_cmd_t          cmd;
	logic [eau_pkg::WordW-1:0]  ac, mq;
	logic                       busy;
	logic                       s_fire;
	logic                       action;
	logic [2:0]                 reg_offset;
	logic [eau_pkg::WordW-1:0]  read_word;
	logic                       m_tvalid_q;
	logic [eau_pkg::WordW-1:0]  m_tdata_q;

	assign action     = s_tuser[0];
	assign reg_offset = s_tuser[3:1];

	assign s_tready = !busy && (!m_tvalid_q || m_tready);
	assign s_fire   = s_tvalid && s_tready;

	always_comb begin
		cmd.start = 1'b0;
		cmd.op    = eau_pkg::OP_LOAD_AC;
		cmd.data  = s_tdata;
		if (s_fire && (action == eau_pkg::ACT_WRITE)) begin
			case (reg_offset)
				eau_pkg::OFS_DIV: begin
					cmd.start = 1'b1;
					cmd.op    = eau_pkg::OP_DIV;
				end
				eau_pkg::OFS_AC: begin
					cmd.start = 1'b1;
					cmd.op    = eau_pkg::OP_LOAD_AC;
				end
				eau_pkg::OFS_MQ: begin
					cmd.start = 1'b1;
					cmd.op    = eau_pkg::OP_LOAD_MQ;
				end
				eau_pkg::OFS_MUL: begin
					cmd.start = 1'b1;
					cmd.op    = eau_pkg::OP_MUL;
				end
				eau_pkg::OFS_SHL, eau_pkg::OFS_SHR: begin
					cmd.start = 1'b1;
					cmd.op    = eau_pkg::OP_SHIFT;
				end
				default: cmd.start = 1'b0;
			endcase
		end
	end

	always_comb begin
		read_word = '0;
		if (action == eau_pkg::ACT_READ) begin
			case (reg_offset)
				eau_pkg::OFS_AC: read_word = ac;
				eau_pkg::OFS_MQ: read_word = mq;
				default:         read_word = '0;
			endcase
		end
	end

	eau_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ac     (ac),
		.mq     (mq),
		.busy   (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			m_tdata_q <= read_word;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !busy)
		else $error("request taken while the engine is busy");

	a_mul_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start && (cmd.op == eau_pkg::OP_MUL)) |=> busy)
		else $error("multiply did not start the serial engine");

	a_read_ac: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && (action == eau_pkg::ACT_READ) && (reg_offset == eau_pkg::OFS_AC))
		|=> (m_tdata == $past(ac)))
		else $error("accumulator read returned a wrong word");

endmodule
